@@ hw/rtl/tmbc_pkg.sv @@
// Package with shared types and constants of the template match block counter.
`timescale 1ns / 1ps

package tmbc_pkg;

  // Widths fixed by the register map and the item fields.
  localparam int PAT_W      = 21;
  localparam int TLEN_W     = 5;
  localparam int BLEN_W     = 21;
  localparam int LAMBDA_W   = 26;
  localparam int INVV_W     = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int BLKNUM_W   = 3;
  localparam int MCOUNT_W   = 21;
  localparam int CHI_W      = 40;

  // Window fill counter saturates at this value.
  localparam int FILL_W     = 5;
  localparam logic [FILL_W-1:0] FILL_MAX = 5'd31;

  // Serial multiplier geometry.
  localparam int MUL_A_W    = 64;
  localparam int MUL_B_W    = 32;
  localparam int MUL_ACC_W  = 66;
  localparam int MUL_CNT_W  = 6;
  // A Q32 product at or above 2^56 rounds to a term beyond the 40-bit ceiling.
  localparam int SAT_BIT    = 56;
  localparam logic [SAT_BIT:0] HALF_Q16 = 57'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMPLATE_PATTERN = 3'd0,
    CFG_TEMPLATE_LEN     = 3'd1,
    CFG_BLOCK_LEN        = 3'd2,
    CFG_LAMBDA           = 3'd3,
    CFG_INV_VAR          = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_COUNT,
    ST_DIFF,
    ST_SQUARE,
    ST_SCALE,
    ST_ROUND,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic data_bit;
  } in_item_t;

  typedef struct packed {
    logic [BLKNUM_W-1:0] block_number;
    logic [MCOUNT_W-1:0] match_count;
    logic [CHI_W-1:0]    chi_square_q16;
    logic                last_block;
    logic                saturated;
  } out_item_t;

  typedef struct packed {
    logic [PAT_W-1:0]  template_pattern;
    logic [TLEN_W-1:0] template_len;
    logic [BLEN_W-1:0] block_len;
  } match_cfg_t;

  typedef struct packed {
    logic start;
    logic sat_en;
  } mul_ctrl_t;

  typedef struct packed {
    logic done;
    logic sat;
  } mul_stat_t;

endpackage

@@ hw/rtl/tmbc_stream_if.sv @@
// Valid/ready stream interface that carries one item per handshake.
`timescale 1ns / 1ps

interface tmbc_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/tmbc_matcher.sv @@
// Bit window, template compare and per-block match counting.
`timescale 1ns / 1ps

module tmbc_matcher import tmbc_pkg::*; #(
  parameter int MAX_TEMPLATE_BITS = 21,
  parameter int COUNT_BITS        = 21
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  data_bit_i,
  input  match_cfg_t            cfg_i,
  output logic                  block_end_o,
  output logic [COUNT_BITS-1:0] count_o
);

  localparam logic [5:0] TL_MAX = 6'(MAX_TEMPLATE_BITS);
  localparam logic [5:0] TL_MIN = 6'd2;

  logic [MAX_TEMPLATE_BITS-1:0] window_q, window_d;
  logic [FILL_W-1:0]            fill_q, fill_inc;
  logic [COUNT_BITS-1:0]        hit_q, hit_inc;
  logic [BLEN_W-1:0]            pos_q, blen;
  logic [5:0]                   tl;
  logic [MAX_TEMPLATE_BITS-1:0] mask, pat;
  logic                         match;

  always_comb begin
    if (6'(cfg_i.template_len) < TL_MIN) begin
      tl = TL_MIN;
    end else if (6'(cfg_i.template_len) > TL_MAX) begin
      tl = TL_MAX;
    end else begin
      tl = 6'(cfg_i.template_len);
    end
    for (int i = 0; i < MAX_TEMPLATE_BITS; i++) begin
      mask[i] = (6'(i) < tl);
    end
  end

  assign pat      = MAX_TEMPLATE_BITS'(cfg_i.template_pattern);
  assign window_d = {window_q[MAX_TEMPLATE_BITS-2:0], data_bit_i};
  assign fill_inc = (fill_q == FILL_MAX) ? fill_q : fill_q + FILL_W'(1);
  assign match    = ({1'b0, fill_inc} >= tl) && (((window_d ^ pat) & mask) == '0);
  assign hit_inc  = (match && (hit_q != '1)) ? hit_q + COUNT_BITS'(1) : hit_q;
  assign blen     = (cfg_i.block_len == '0) ? BLEN_W'(1) : cfg_i.block_len;

  assign block_end_o = accept_i && (({1'b0, pos_q} + (BLEN_W + 1)'(1)) >= {1'b0, blen});
  assign count_o     = hit_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
      hit_q    <= '0;
      pos_q    <= '0;
    end else if (accept_i) begin
      window_q <= window_d;
      if (block_end_o) begin
        fill_q <= '0;
        hit_q  <= '0;
        pos_q  <= '0;
      end else begin
        fill_q <= match ? '0 : fill_inc;
        hit_q  <= hit_inc;
        pos_q  <= pos_q + BLEN_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/tmbc_serial_mul.sv @@
// Shift-and-add multiplier that consumes one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps

module tmbc_serial_mul import tmbc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mul_ctrl_t            ctrl_i,
  input  logic [MUL_A_W-1:0]   mcand_i,
  input  logic [MUL_B_W-1:0]   mplier_i,
  output mul_stat_t            stat_o,
  output logic [MUL_ACC_W-1:0] product_o
);

  localparam logic [MUL_ACC_W-1:0] SAT_VAL = MUL_ACC_W'(1) << SAT_BIT;

  logic [MUL_ACC_W-1:0] acc_q, step, acc_next;
  logic [MUL_A_W-1:0]   mcand_q;
  logic [MUL_B_W-1:0]   mplier_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 sat_en_q, sat_q, done_q, over;

  assign step     = {acc_q[MUL_ACC_W-2:0], 1'b0}
                  + (mplier_q[MUL_B_W-1] ? MUL_ACC_W'(mcand_q) : '0);
  // The partial sum only grows, so once past the ceiling it can be pinned there.
  assign over     = sat_en_q && (step >= SAT_VAL);
  assign acc_next = over ? SAT_VAL : step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sat_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == MUL_CNT_W'(1)) && !ctrl_i.start;
      if (ctrl_i.start) begin
        cnt_q <= MUL_CNT_W'(MUL_B_W);
        sat_q <= 1'b0;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - MUL_CNT_W'(1);
        sat_q <= sat_q | over;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q    <= '0;
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      sat_en_q <= ctrl_i.sat_en;
    end else if (cnt_q != '0) begin
      acc_q    <= acc_next;
      mplier_q <= {mplier_q[MUL_B_W-2:0], 1'b0};
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.sat  = sat_q;
  assign product_o   = acc_q;

endmodule

@@ hw/rtl/template_match_block_counter.sv @@
// Top level of the non-overlapping template match block counter.
`timescale 1ns / 1ps

// The block takes one sequence bit per item and scans each block of block_len bits for the
// configured template, restarting the scan behind every match and never letting a window
// cross a block boundary. Inside a block an item is accepted every cycle. At the last bit
// of a block the input stalls while the chi-square term ((count - lambda)^2 * inv_var,
// Q16, rounded half up) is formed by one shared shift-and-add multiplier that takes one
// multiplier bit per cycle: it squares the difference, then scales it by the inverse
// variance, and the product is rounded. A difference of 2^32 or more skips the multiplier
// and saturates the term unless the inverse variance is zero. The term is added to a
// saturating 40-bit sum, and the result item for the block is placed in an output register;
// the next block's bits are accepted while that item waits to be taken, but the following
// block end waits until the register is free. The item of the final block carries
// last_block, after which the block counter, the sum and the saturation flag start over.
// Configuration writes are registered and are expected only while no block end is in progress.

module template_match_block_counter import tmbc_pkg::*; #(
  parameter int BLOCKS            = 8,
  parameter int MAX_TEMPLATE_BITS = 21,
  parameter int COUNT_BITS        = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tmbc_stream_if.sink          in_i,
  tmbc_stream_if.source        out_o
);

  localparam int BLK_W    = $clog2(BLOCKS);
  localparam int SCALED_W = COUNT_BITS + 8;
  localparam int DIFF_W   = (SCALED_W > LAMBDA_W) ? SCALED_W : LAMBDA_W;
  localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCKS - 1);

  // Configuration registers.
  logic [PAT_W-1:0]    pattern_q;
  logic [TLEN_W-1:0]   tlen_q;
  logic [BLEN_W-1:0]   blen_q;
  logic [LAMBDA_W-1:0] lambda_q;
  logic [INVV_W-1:0]   inv_var_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      tlen_q    <= TLEN_W'(9);
      blen_q    <= BLEN_W'(1024);
      lambda_q  <= '0;
      inv_var_q <= INVV_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TEMPLATE_PATTERN: pattern_q <= cfg_data_i[PAT_W-1:0];
        CFG_TEMPLATE_LEN:     tlen_q    <= cfg_data_i[TLEN_W-1:0];
        CFG_BLOCK_LEN:        blen_q    <= cfg_data_i[BLEN_W-1:0];
        CFG_LAMBDA:           lambda_q  <= cfg_data_i[LAMBDA_W-1:0];
        CFG_INV_VAR:          inv_var_q <= cfg_data_i[INVV_W-1:0];
        default: ;
      endcase
    end
  end

  // Bit scanning and per-block counting.
  match_cfg_t            match_cfg;
  logic                  in_accept, in_ready, block_end;
  logic [COUNT_BITS-1:0] count_next;

  assign match_cfg.template_pattern = pattern_q;
  assign match_cfg.template_len     = tlen_q;
  assign match_cfg.block_len        = blen_q;
  assign in_accept = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  tmbc_matcher #(
    .MAX_TEMPLATE_BITS (MAX_TEMPLATE_BITS),
    .COUNT_BITS        (COUNT_BITS)
  ) u_matcher (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_bit_i  (in_i.payload.data_bit),
    .cfg_i       (match_cfg),
    .block_end_o (block_end),
    .count_o     (count_next)
  );

  // Shared serial multiplier.
  mul_ctrl_t            mul_ctrl;
  mul_stat_t            mul_stat;
  logic [MUL_A_W-1:0]   mul_mcand;
  logic [MUL_B_W-1:0]   mul_mplier;
  logic [MUL_ACC_W-1:0] mul_product;

  tmbc_serial_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mul_ctrl),
    .mcand_i   (mul_mcand),
    .mplier_i  (mul_mplier),
    .stat_o    (mul_stat),
    .product_o (mul_product)
  );

  // Sequencer state and datapath registers.
  state_e                state_q, state_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [SAT_BIT-1:0]    full_q, full_d;
  logic                  term_sat_q, term_sat_d;
  logic [CHI_W-1:0]      term_q, term_d;
  logic [CHI_W-1:0]      chi_q, chi_d;
  logic                  ovf_q, ovf_d;
  logic [BLK_W-1:0]      blk_q, blk_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  logic [DIFF_W-1:0]  scaled, lam, diff;
  logic [MUL_A_W-1:0] diff_wide;
  logic               diff_big, last, emit_ok, clamp;
  logic [SAT_BIT:0]   rnd;
  logic [CHI_W:0]     sum;
  logic [CHI_W-1:0]   chi_new;

  always_comb begin
    scaled    = DIFF_W'({count_q, 8'd0});
    lam       = DIFF_W'(lambda_q);
    diff      = (scaled >= lam) ? scaled - lam : lam - scaled;
    diff_wide = MUL_A_W'(diff);
    // A difference of 2^32 or more squares past any representable term.
    diff_big  = (diff_wide[MUL_A_W-1:MUL_B_W] != '0);
    rnd       = {1'b0, full_q} + HALF_Q16;
    sum       = {1'b0, chi_q} + {1'b0, term_q};
    clamp     = term_sat_q || sum[CHI_W];
    chi_new   = clamp ? '1 : sum[CHI_W-1:0];
    last      = (blk_q == BLK_LAST);
    emit_ok   = !out_valid_q || out_o.ready;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    full_d      = full_q;
    term_sat_d  = term_sat_q;
    term_d      = term_q;
    chi_d       = chi_q;
    ovf_d       = ovf_q;
    blk_d       = blk_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_item_d  = out_item_q;
    in_ready    = 1'b0;
    mul_ctrl    = '0;
    mul_mcand   = diff_wide;
    mul_mplier  = diff_wide[MUL_B_W-1:0];

    unique case (state_q)
      ST_COUNT: begin
        in_ready = 1'b1;
        if (block_end) begin
          count_d = count_next;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (diff_big) begin
          full_d     = '0;
          term_sat_d = (inv_var_q != '0);
          state_d    = ST_ROUND;
        end else begin
          mul_ctrl.start = 1'b1;
          term_sat_d     = 1'b0;
          state_d        = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        mul_mcand  = mul_product[MUL_A_W-1:0];
        mul_mplier = inv_var_q;
        if (mul_stat.done) begin
          mul_ctrl.start  = 1'b1;
          mul_ctrl.sat_en = 1'b1;
          state_d         = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (mul_stat.done) begin
          full_d     = mul_product[SAT_BIT-1:0];
          term_sat_d = mul_stat.sat || (mul_product[MUL_ACC_W-1:SAT_BIT] != '0);
          state_d    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        term_d     = rnd[SAT_BIT-1:16];
        term_sat_d = term_sat_q || rnd[SAT_BIT];
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        if (emit_ok) begin
          out_valid_d                = 1'b1;
          out_item_d.block_number    = BLKNUM_W'(blk_q);
          out_item_d.match_count     = MCOUNT_W'(count_q);
          out_item_d.chi_square_q16  = chi_new;
          out_item_d.last_block      = last;
          out_item_d.saturated       = ovf_q || clamp;
          if (last) begin
            chi_d = '0;
            ovf_d = 1'b0;
            blk_d = '0;
          end else begin
            chi_d = chi_new;
            ovf_d = ovf_q || clamp;
            blk_d = blk_q + BLK_W'(1);
          end
          state_d = ST_COUNT;
        end
      end
      default: state_d = ST_COUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COUNT;
      chi_q       <= '0;
      ovf_q       <= 1'b0;
      blk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chi_q       <= chi_d;
      ovf_q       <= ovf_d;
      blk_q       <= blk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q    <= count_d;
    full_q     <= full_d;
    term_sat_q <= term_sat_d;
    term_q     <= term_d;
    out_item_q <= out_item_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

@@ hw/rtl/tmbc_checker.sv @@
// Port-level checker for the template match block counter, with its bind.
`timescale 1ns / 1ps

module tmbc_checker import tmbc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i
);

  logic                out_acc;
  logic                prev_last_q;
  logic [BLKNUM_W-1:0] prev_num_q;
  logic [CHI_W-1:0]    prev_chi_q;

  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_last_q <= 1'b1;
      prev_num_q  <= '0;
      prev_chi_q  <= '0;
    end else if (out_acc) begin
      prev_last_q <= out_item_i.last_block;
      prev_num_q  <= out_item_i.block_number;
      prev_chi_q  <= out_item_i.chi_square_q16;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result item changed while stalled");

  a_seq_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && prev_last_q |-> out_item_i.block_number == '0)
    else $error("sequence did not start at block zero");

  a_seq_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !prev_last_q |-> out_item_i.block_number == prev_num_q + BLKNUM_W'(1))
    else $error("block number skipped");

  a_sum_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !prev_last_q |-> out_item_i.chi_square_q16 >= prev_chi_q)
    else $error("chi-square sum decreased within a sequence");

  a_sat_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.saturated |-> out_item_i.chi_square_q16 == '1)
    else $error("saturated sum below its ceiling");

endmodule

bind template_match_block_counter tmbc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);

@@ test/tmbc_result_check.sv @@
// Checker that predicts and compares the result items of the template match block counter.
`timescale 1ns / 1ps

module tmbc_result_check import tmbc_pkg::*; #(
  parameter int BLOCKS            = 8,
  parameter int MAX_TEMPLATE_BITS = 21,
  parameter int COUNT_BITS        = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 bit_valid_i,
  input  logic                 bit_ready_i,
  input  in_item_t             bit_item_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  out_item_t            res_item_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o
);

  localparam logic [CHI_W-1:0]      CHI_CEIL   = {CHI_W{1'b1}};
  localparam logic [COUNT_BITS-1:0] HIT_CEIL   = {COUNT_BITS{1'b1}};

  // Register copies.
  logic [PAT_W-1:0]    pattern_q;
  logic [TLEN_W-1:0]   tlen_q;
  logic [BLEN_W-1:0]   blen_q;
  logic [LAMBDA_W-1:0] lambda_q;
  logic [INVV_W-1:0]   invv_q;

  // Scan and sum state.
  logic [MAX_TEMPLATE_BITS-1:0] window_q;
  logic [BLEN_W-1:0]            pos_q;
  int unsigned                  blk_q;
  logic [COUNT_BITS-1:0]        hits_q;
  logic [CHI_W-1:0]             chi_q;
  logic                         ovf_q;
  logic [FILL_W-1:0]            fill_q;

  out_item_t   block_results_q[$];
  int unsigned mismatches;
  int unsigned checked;

  // Chi-square term of one block in Q16, with the clamp flag on top.
  function automatic logic [CHI_W:0] block_term(input logic [COUNT_BITS-1:0] hits);
    logic [127:0] scaled, gap, prod;
    if (invv_q == '0) return '0;
    scaled = 128'(hits) << 8;
    gap = (scaled >= 128'(lambda_q)) ? scaled - 128'(lambda_q) : 128'(lambda_q) - scaled;
    if (gap >= (128'd1 << 32)) return {1'b1, CHI_CEIL};
    prod = (gap * gap * 128'(invv_q) + 128'h8000) >> 16;
    if (prod > 128'(CHI_CEIL)) return {1'b1, CHI_CEIL};
    return {1'b0, prod[CHI_W-1:0]};
  endfunction

  task apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (cfg_idx_e'(idx))
      CFG_TEMPLATE_PATTERN: pattern_q = data[PAT_W-1:0];
      CFG_TEMPLATE_LEN:     tlen_q    = data[TLEN_W-1:0];
      CFG_BLOCK_LEN:        blen_q    = data[BLEN_W-1:0];
      CFG_LAMBDA:           lambda_q  = data[LAMBDA_W-1:0];
      CFG_INV_VAR:          invv_q    = data[INVV_W-1:0];
      default: ;
    endcase
  endtask

  // Shifts one sequence bit in and queues a result when it closes a block.
  task advance(input logic data_bit);
    int unsigned    tl;
    logic [31:0]    tmask;
    logic [31:0]    blen_eff;
    logic [CHI_W:0] term;
    logic [CHI_W:0] sum;
    logic           last;
    out_item_t      res;
    tl = 32'(tlen_q);
    if (tl < 2) tl = 2;
    if (tl > MAX_TEMPLATE_BITS) tl = MAX_TEMPLATE_BITS;
    tmask = 32'hFFFF_FFFF >> (32 - tl);
    window_q = {window_q[MAX_TEMPLATE_BITS-2:0], data_bit};
    if (fill_q != FILL_MAX) fill_q = fill_q + 1'b1;
    // A match restarts the fill so that the next window starts behind it.
    if (fill_q >= tl && (32'(window_q) & tmask) == (32'(pattern_q) & tmask)) begin
      if (hits_q != HIT_CEIL) hits_q = hits_q + 1'b1;
      fill_q = '0;
    end
    blen_eff = (blen_q == '0) ? 32'd1 : 32'(blen_q);
    if (32'(pos_q) + 32'd1 < blen_eff) begin
      pos_q = pos_q + 1'b1;
      return;
    end
    term = block_term(hits_q);
    sum = {1'b0, chi_q} + {1'b0, term[CHI_W-1:0]};
    if (term[CHI_W] || sum > {1'b0, CHI_CEIL}) begin
      sum = {1'b0, CHI_CEIL};
      ovf_q = 1'b1;
    end
    chi_q = sum[CHI_W-1:0];
    last = (blk_q + 1 >= BLOCKS);
    res.block_number   = BLKNUM_W'(blk_q);
    res.match_count    = MCOUNT_W'(hits_q);
    res.chi_square_q16 = chi_q;
    res.last_block     = last;
    res.saturated      = ovf_q;
    block_results_q.push_back(res);
    pos_q  = '0;
    hits_q = '0;
    fill_q = '0;
    if (last) begin
      blk_q = 0;
      chi_q = '0;
      ovf_q = 1'b0;
    end else begin
      blk_q++;
    end
  endtask

  task report_field(input string field, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  task check_result(input out_item_t got);
    out_item_t want;
    if (block_results_q.size() == 0) begin
      mismatches++;
      $display("%0t: result item with none expected, expected none, actual 0x%0h",
               $time, got);
      return;
    end
    want = block_results_q.pop_front();
    checked++;
    report_field("block_number", 64'(want.block_number), 64'(got.block_number));
    report_field("match_count", 64'(want.match_count), 64'(got.match_count));
    report_field("chi_square_q16", 64'(want.chi_square_q16), 64'(got.chi_square_q16));
    report_field("last_block", 64'(want.last_block), 64'(got.last_block));
    report_field("saturated", 64'(want.saturated), 64'(got.saturated));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q = '0;
      tlen_q    = TLEN_W'(9);
      blen_q    = BLEN_W'(1024);
      lambda_q  = '0;
      invv_q    = INVV_W'(65536);
      window_q  = '0;
      pos_q     = '0;
      blk_q     = 0;
      hits_q    = '0;
      chi_q     = '0;
      ovf_q     = 1'b0;
      fill_q    = '0;
      block_results_q.delete();
      mismatches = 0;
      checked    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // Results leaving now belong to earlier bits, so they are checked first. A bit taken
      // at the same edge as a register write still sees the old register value.
      if (res_valid_i && res_ready_i) check_result(res_item_i);
      if (bit_valid_i && bit_ready_i) advance(bit_item_i.data_bit);
      if (cfg_we_i) apply_write(cfg_index_i, cfg_data_i);
      fail_count_o <= mismatches;
      pending_o    <= block_results_q.size();
      checked_o    <= checked;
    end
  end

endmodule

@@ test/testbench.sv @@
// Top of the template match block counter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// The block is fed one sequence bit per item and returns one result item per finished block.
// A checker beside the block watches both channels and the register port, keeps its own
// copy of the scan state, and compares every result item with its prediction. This module
// only drives stimulus: a short directed part, then phases of random register settings
// with bit streams that are mostly the template itself with some noise, plain noise, or
// long runs of one value. Registers are rewritten only after every expected result item
// has come back and the block has had time to settle.
module testbench;
  import tmbc_pkg::*;

  localparam int          BLOCKS            = 8;
  localparam int          MAX_TEMPLATE_BITS = 21;
  localparam int          COUNT_BITS        = 21;
  localparam int unsigned RANDOM_ITEMS      = 1500;
  // Settling time that covers any work still under way at a block end.
  localparam int unsigned SETTLE_CYCLES     = 100;
  localparam int unsigned HOLD_CYCLES       = 400;
  localparam int unsigned CYCLE_LIMIT       = 1_000_000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  tmbc_stream_if #(.item_t(in_item_t))  bit_ch ();
  tmbc_stream_if #(.item_t(out_item_t)) res_ch ();

  int unsigned fail_count;
  int unsigned pending_items;
  int unsigned results_checked;

  // Stimulus bookkeeping.
  int unsigned       cycle_count = 0;
  int unsigned       bits_sent = 0;
  int unsigned       settings_used = 0;
  int unsigned       hold_asked = 0;
  int unsigned       hold_served = 0;
  bit                tx_steady = 1'b0;
  bit                rx_steady = 1'b0;
  logic [PAT_W-1:0]  cur_pattern;
  int unsigned       cur_tlen;

  template_match_block_counter #(
    .BLOCKS            (BLOCKS),
    .MAX_TEMPLATE_BITS (MAX_TEMPLATE_BITS),
    .COUNT_BITS        (COUNT_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (bit_ch),
    .out_o       (res_ch)
  );

  tmbc_result_check #(
    .BLOCKS            (BLOCKS),
    .MAX_TEMPLATE_BITS (MAX_TEMPLATE_BITS),
    .COUNT_BITS        (COUNT_BITS)
  ) result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .bit_valid_i  (bit_ch.valid),
    .bit_ready_i  (bit_ch.ready),
    .bit_item_i   (bit_ch.payload),
    .res_valid_i  (res_ch.valid),
    .res_ready_i  (res_ch.ready),
    .res_item_i   (res_ch.payload),
    .fail_count_o (fail_count),
    .pending_o    (pending_items),
    .checked_o    (results_checked)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: a correct run ends far below this limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d result items outstanding.",
               cycle_count, pending_items);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result receiver. It stalls about one cycle in five, never during a steady phase, and
  // holds off completely for a long stretch whenever the stimulus asks for it. During that
  // stretch the block's output register fills and the input must stall.
  initial begin : receiver
    int unsigned held;
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_asked) begin
        hold_served++;
        res_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
      end else if (rx_steady) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Offers one bit and returns at the edge where it is accepted, with valid still high.
  task automatic send_bit(input logic data_bit);
    if (!tx_steady) begin
      while ($urandom_range(0, 99) < 20) begin
        bit_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    bit_ch.valid   <= 1'b1;
    bit_ch.payload <= '{data_bit: data_bit};
    do @(posedge clk_i); while (!bit_ch.ready);
    bits_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  // Writes all five registers back to back; the block must be idle here.
  task automatic configure(input logic [PAT_W-1:0] pattern, input logic [TLEN_W-1:0] tlen,
                           input logic [BLEN_W-1:0] blen, input logic [LAMBDA_W-1:0] lambda,
                           input logic [INVV_W-1:0] inv_var);
    write_reg(CFG_TEMPLATE_PATTERN, CFG_W'(pattern));
    write_reg(CFG_TEMPLATE_LEN, CFG_W'(tlen));
    write_reg(CFG_BLOCK_LEN, CFG_W'(blen));
    write_reg(CFG_LAMBDA, CFG_W'(lambda));
    write_reg(CFG_INV_VAR, CFG_W'(inv_var));
    cfg_we_i <= 1'b0;
    cur_pattern = pattern;
    cur_tlen = (tlen < 2) ? 2 : ((tlen > MAX_TEMPLATE_BITS) ? MAX_TEMPLATE_BITS : tlen);
    settings_used++;
  endtask

  // Stops offering bits, waits for every expected result item, then lets the block settle.
  task automatic drain();
    bit_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_items != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sends a stream of bits in one of three shapes. Half of the streams repeat the template from
  // its first compared bit on, with a random bit slipped in now and then, so that matches
  // are found even for long templates.
  task automatic run_bits(input int unsigned n_bits);
    int unsigned shape, tpl_left, run_left;
    logic        run_val, next_bit;
    shape = $urandom_range(0, 9);
    tpl_left = 0;
    run_left = 0;
    run_val = 1'b0;
    for (int unsigned k = 0; k < n_bits; k++) begin
      if (shape < 5) begin
        if (tpl_left == 0 && $urandom_range(0, 7) != 0) tpl_left = cur_tlen;
        if (tpl_left == 0) begin
          next_bit = 1'($urandom_range(0, 1));
        end else begin
          tpl_left--;
          next_bit = cur_pattern[tpl_left];
        end
      end else if (shape < 8) begin
        next_bit = 1'($urandom_range(0, 1));
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 30);
          run_val = 1'($urandom_range(0, 1));
        end
        run_left--;
        next_bit = run_val;
      end
      send_bit(next_bit);
    end
  endtask

  // Random register setting, weighted toward short templates and short blocks so that
  // matches and block ends are frequent, with most register extremes mixed in.
  task automatic random_config(output int unsigned blen_eff);
    logic [PAT_W-1:0]    pattern;
    logic [TLEN_W-1:0]   tlen;
    logic [BLEN_W-1:0]   blen;
    logic [LAMBDA_W-1:0] lambda;
    logic [INVV_W-1:0]   inv_var;
    case ($urandom_range(0, 4))
      0:       pattern = '0;
      1:       pattern = '1;
      default: pattern = PAT_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       tlen = TLEN_W'($urandom_range(0, 1));
      1:       tlen = TLEN_W'($urandom_range(22, 31));
      2:       tlen = TLEN_W'(21);
      3:       tlen = TLEN_W'($urandom_range(10, 20));
      default: tlen = TLEN_W'($urandom_range(2, 5));
    endcase
    case ($urandom_range(0, 19))
      0:       blen = BLEN_W'($urandom_range(0, 1));
      1:       blen = BLEN_W'($urandom_range(100, 400));
      default: blen = BLEN_W'($urandom_range(2, 48));
    endcase
    case ($urandom_range(0, 4))
      0:       lambda = '0;
      1:       lambda = '1;
      2:       lambda = LAMBDA_W'($urandom);
      default: lambda = LAMBDA_W'($urandom_range(0, 4096));
    endcase
    case ($urandom_range(0, 5))
      0:       inv_var = '0;
      1:       inv_var = '1;
      2:       inv_var = $urandom;
      3:       inv_var = INVV_W'(65536);
      default: inv_var = $urandom_range(1, 1 << 20);
    endcase
    configure(pattern, tlen, blen, lambda, inv_var);
    blen_eff = (blen == 0) ? 1 : blen;
  endtask

  initial begin : stimulus
    int unsigned directed_bits, random_phase, blen_eff, n_bits;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    bit_ch.valid   = 1'b0;
    bit_ch.payload = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero block length acts as one bit per block, and a template length below two acts
    // as two, so every bit closes a block with no match. The largest lambda and inverse
    // variance force the sum to its ceiling, and nine blocks cross a sequence end.
    configure('1, TLEN_W'(1), BLEN_W'(0), '1, '1);
    for (int unsigned k = 0; k < 9; k++) send_bit(k[0]);
    drain();

    // A template length above the limit acts as the limit; single-bit blocks stay far
    // shorter than the template, and a zero inverse variance gives a zero term.
    configure('1, TLEN_W'(31), BLEN_W'(1), '0, '0);
    for (int unsigned k = 0; k < 4; k++) send_bit(1'b1);
    drain();

    // Two-bit template "10" in an eight-bit block: matches must not overlap.
    configure(PAT_W'(2), TLEN_W'(2), BLEN_W'(8), LAMBDA_W'(256), INVV_W'(65536));
    run_fixed: begin
      logic [7:0] stream;
      stream = 8'b1010_0101;
      for (int k = 7; k >= 0; k--) send_bit(stream[k]);
    end
    drain();
    directed_bits = bits_sent;

    random_phase = 0;
    while (bits_sent - directed_bits < RANDOM_ITEMS) begin
      if (random_phase == 1) begin
        // Neither side idles for a long stretch.
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_config(blen_eff);
        run_bits(300);
        drain();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end else if (random_phase == 3) begin
        // One long block with the default template length.
        blen_eff = $urandom_range(900, 1100);
        configure(PAT_W'($urandom), TLEN_W'(9), BLEN_W'(blen_eff),
                  LAMBDA_W'($urandom_range(0, 8192)), INVV_W'(65536));
        run_bits(blen_eff + 20);
        drain();
      end else if (random_phase == 2) begin
        // Tiny blocks while the receiver holds off: the output register fills and the
        // block must stop taking bits until the receiver comes back.
        configure(PAT_W'($urandom), TLEN_W'(2), BLEN_W'($urandom_range(2, 3)),
                  LAMBDA_W'(512), INVV_W'(65536));
        hold_asked++;
        run_bits(120);
        drain();
      end else begin
        random_config(blen_eff);
        if (blen_eff < 4) n_bits = $urandom_range(5, 20);
        else n_bits = blen_eff * $urandom_range(1, 3) + $urandom_range(0, blen_eff);
        if (n_bits > 200) n_bits = 200;
        run_bits(n_bits);
        drain();
      end
      random_phase++;
    end

    $display("Covered %0d sequence bits under %0d register settings.", bits_sent,
             settings_used);
    $display("Checked %0d block result items, with %0d mismatches.", results_checked,
             fail_count);
    if (fail_count == 0 && pending_items == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tmbc_pkg.sv
hw/rtl/tmbc_stream_if.sv
hw/rtl/tmbc_matcher.sv
hw/rtl/tmbc_serial_mul.sv
hw/rtl/template_match_block_counter.sv
hw/rtl/tmbc_checker.sv
test/tmbc_result_check.sv
test/testbench.sv
